>>> rtl/signed_add_sub_mul_div_unit_defines.svh
// Assertion macros for the signed add/subtract/multiply/divide unit.
`ifndef SIGNED_ADD_SUB_MUL_DIV_UNIT_DEFINES_SVH
`define SIGNED_ADD_SUB_MUL_DIV_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property at every rising clock edge outside reset.
`define SASMD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition in one cycle implies another in the next cycle.
`define SASMD_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SASMD_ASSERT(lbl, clk, rst, prop, msg)
`define SASMD_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

>>> rtl/sasmd_pkg.sv
// Shared types and constants of the signed add/subtract/multiply/divide unit.
package sasmd_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE         = 2'd0,
      ERR_MUL_OVERFLOW = 2'd1,
      ERR_DIV_ZERO     = 2'd2
   } err_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADDSUB,
      S_MAG_A,
      S_MAG_B,
      S_MUL,
      S_DIV,
      S_FIX_REM,
      S_FIX_QUO,
      S_FINISH
   } state_type;

   typedef enum logic [3:0] {
      UOP_NONE,
      UOP_LOAD,
      UOP_ADDSUB,
      UOP_MAG_A,
      UOP_MAG_B,
      UOP_MUL,
      UOP_DIV,
      UOP_FIX_REM,
      UOP_FIX_QUO,
      UOP_FINISH
   } uop_type;

   typedef struct packed {
      uop_type uop;
      logic    rsp_load;
   } ctrl_type;

   typedef struct packed {
      op_type op;
      logic   a_neg;
      logic   b_zero;
      logic   acc_zero;
      logic   out_free;
   } status_type;

endpackage

>>> rtl/sasmd_alu.sv
// Shared adder/subtractor for the arithmetic micro-operations.
module sasmd_alu #(
   parameter int WIDTH = sasmd_pkg::DATA_WIDTH_DEFAULT + 2
) (
   input  logic [WIDTH-1:0] alu_x,
   input  logic [WIDTH-1:0] alu_y,
   input  logic             alu_sub,
   output logic [WIDTH-1:0] alu_sum
);
   logic [WIDTH-1:0] y_eff;

   assign y_eff   = alu_sub ? ~alu_y : alu_y;
   assign alu_sum = alu_x + y_eff + WIDTH'(alu_sub);

endmodule

>>> rtl/sasmd_seq.sv
// Sequencer: walks one transaction through set-up, bit steps and correction.
module sasmd_seq #(
   parameter int DATA_WIDTH = sasmd_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  sasmd_pkg::op_type      req_operation,
   input  sasmd_pkg::status_type  status,
   output sasmd_pkg::ctrl_type    ctrl,
   output logic                   req_stall
);
   import sasmd_pkg::*;

   localparam int CNT_W = $clog2(DATA_WIDTH);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             cnt_last;

   assign cnt_last = (cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and bit counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_operation) inside
                  OP_ADD, OP_SUB: state_in = S_ADDSUB;
                  OP_MUL, OP_DIV: state_in = S_MAG_A;
                  default:        state_in = S_IDLE;
               endcase
            end
         end
         S_MAG_A: state_in = S_MAG_B;
         S_MAG_B: begin
            cnt_in = CNT_W'(DATA_WIDTH - 1);
            if (status.op == OP_MUL) begin
               state_in = S_MUL;
            end else if (status.b_zero) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_DIV;
            end
         end
         S_MUL: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_last) begin
               state_in = S_FINISH;
            end
         end
         S_DIV: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_last) begin
               state_in = status.a_neg ? S_FIX_REM : S_FINISH;
            end
         end
         S_FIX_REM: state_in = status.acc_zero ? S_FINISH : S_FIX_QUO;
         S_FIX_QUO: state_in = S_FINISH;
         S_ADDSUB, S_FINISH: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // micro-operation for the datapath
   always_comb begin
      ctrl.uop      = UOP_NONE;
      ctrl.rsp_load = 1'b0;
      req_stall     = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE:    ctrl.uop = req_valid ? UOP_LOAD : UOP_NONE;
         S_MAG_A:   ctrl.uop = UOP_MAG_A;
         S_MAG_B:   ctrl.uop = UOP_MAG_B;
         S_MUL:     ctrl.uop = UOP_MUL;
         S_DIV:     ctrl.uop = UOP_DIV;
         S_FIX_REM: ctrl.uop = status.acc_zero ? UOP_NONE : UOP_FIX_REM;
         S_FIX_QUO: ctrl.uop = UOP_FIX_QUO;
         S_ADDSUB: begin
            if (status.out_free) begin
               ctrl.uop      = UOP_ADDSUB;
               ctrl.rsp_load = 1'b1;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               ctrl.uop      = UOP_FINISH;
               ctrl.rsp_load = 1'b1;
            end
         end
         default: ctrl.uop = UOP_NONE;
      endcase
   end

endmodule

>>> rtl/sasmd_datapath.sv
// Operand, accumulator and result registers around the shared adder.
module sasmd_datapath #(
   parameter int DATA_WIDTH = sasmd_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sasmd_pkg::ctrl_type          ctrl,
   output sasmd_pkg::status_type        status,
   input  sasmd_pkg::op_type            req_operation,
   input  logic signed [DATA_WIDTH-1:0] req_operand_a,
   input  logic signed [DATA_WIDTH-1:0] req_operand_b,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_result_value,
   output logic        [DATA_WIDTH-2:0] rsp_remainder_value,
   output logic        [1:0]            rsp_error_code
);
   import sasmd_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int AW = DATA_WIDTH + 2;

   logic [W-1:0] a_ff, a_in;
   logic [W-1:0] b_ff, b_in;
   logic [W:0]   acc_ff, acc_in;
   op_type       op_ff, op_in;
   logic         a_neg_ff, a_neg_in;
   logic         neg_ff, neg_in;
   logic         ovf_ff, ovf_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] res_ff, res_in;
   logic [W-2:0] rem_ff, rem_in;
   err_type      err_ff, err_in;

   logic [AW-1:0] alu_x, alu_y, alu_sum;
   logic          alu_sub;
   logic          b_zero;
   logic          out_free;

   assign b_zero   = (b_ff == '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign status.op       = op_ff;
   assign status.a_neg    = a_neg_ff;
   assign status.b_zero   = b_zero;
   assign status.acc_zero = (acc_ff == '0);
   assign status.out_free = out_free;

   sasmd_alu #(
      .WIDTH(AW)
   ) u_alu (
      .alu_x  (alu_x),
      .alu_y  (alu_y),
      .alu_sub(alu_sub),
      .alu_sum(alu_sum)
   );

   // operand routing into the shared adder
   always_comb begin
      alu_x   = '0;
      alu_y   = '0;
      alu_sub = 1'b0;
      unique case (ctrl.uop)
         UOP_ADDSUB: begin
            alu_x   = {2'b00, a_ff};
            alu_y   = {2'b00, b_ff};
            alu_sub = (op_ff == OP_SUB);
         end
         UOP_MAG_A: begin
            alu_y   = {2'b00, a_ff};
            alu_sub = 1'b1;
         end
         UOP_MAG_B: begin
            alu_y   = {2'b00, b_ff};
            alu_sub = 1'b1;
         end
         UOP_MUL: begin
            // double the partial product, add the multiplicand for a set bit
            alu_x = {1'b0, acc_ff[W-1:0], 1'b0};
            alu_y = b_ff[W-1] ? {2'b00, a_ff} : '0;
         end
         UOP_DIV: begin
            // shift in the next dividend bit and trial-subtract the divisor
            alu_x   = {1'b0, acc_ff[W-1:0], a_ff[W-1]};
            alu_y   = {2'b00, b_ff};
            alu_sub = 1'b1;
         end
         UOP_FIX_REM: begin
            alu_x   = {2'b00, b_ff};
            alu_y   = {1'b0, acc_ff};
            alu_sub = 1'b1;
         end
         UOP_FIX_QUO: begin
            alu_x = {2'b00, a_ff};
            alu_y = AW'(1);
         end
         UOP_FINISH: begin
            alu_y   = (op_ff == OP_MUL) ? {2'b00, acc_ff[W-1:0]} : {2'b00, a_ff};
            alu_sub = 1'b1;
         end
         default: begin
            alu_x   = '0;
            alu_y   = '0;
            alu_sub = 1'b0;
         end
      endcase
   end

   // working registers
   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      op_in    = op_ff;
      a_neg_in = a_neg_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      unique case (ctrl.uop)
         UOP_LOAD: begin
            a_in     = req_operand_a;
            b_in     = req_operand_b;
            op_in    = req_operation;
            a_neg_in = req_operand_a[W-1];
            neg_in   = req_operand_a[W-1] ^ req_operand_b[W-1];
            acc_in   = '0;
            ovf_in   = 1'b0;
         end
         UOP_MAG_A: begin
            if (a_neg_ff) begin
               a_in = alu_sum[W-1:0];
            end
         end
         UOP_MAG_B: begin
            if (b_ff[W-1]) begin
               b_in = alu_sum[W-1:0];
            end
         end
         UOP_MUL: begin
            // once the product passes the positive limit the overflow flag stays set
            acc_in = alu_sum[W:0];
            ovf_in = ovf_ff | (|alu_sum[AW-1:W-1]);
            b_in   = {b_ff[W-2:0], 1'b0};
         end
         UOP_DIV: begin
            acc_in = alu_sum[AW-1] ? alu_x[W:0] : alu_sum[W:0];
            a_in   = {a_ff[W-2:0], ~alu_sum[AW-1]};
         end
         UOP_FIX_REM: acc_in = alu_sum[W:0];
         UOP_FIX_QUO: a_in   = alu_sum[W-1:0];
         default: begin
            a_in = a_ff;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      res_in       = res_ff;
      rem_in       = rem_ff;
      err_in       = err_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.rsp_load) begin
         rsp_valid_in = 1'b1;
         res_in       = '0;
         rem_in       = '0;
         err_in       = ERR_NONE;
         case (op_ff) inside
            OP_ADD, OP_SUB: res_in = alu_sum[W-1:0];
            OP_MUL: begin
               if (ovf_ff) begin
                  err_in = ERR_MUL_OVERFLOW;
               end else begin
                  res_in = neg_ff ? alu_sum[W-1:0] : acc_ff[W-1:0];
               end
            end
            default: begin
               if (b_zero) begin
                  err_in = ERR_DIV_ZERO;
               end else begin
                  res_in = neg_ff ? alu_sum[W-1:0] : a_ff;
                  rem_in = acc_ff[W-2:0];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      op_ff    <= op_in;
      a_neg_ff <= a_neg_in;
      neg_ff   <= neg_in;
      ovf_ff   <= ovf_in;
      res_ff   <= res_in;
      rem_ff   <= rem_in;
      err_ff   <= err_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_value    = res_ff;
   assign rsp_remainder_value = rem_ff;
   assign rsp_error_code      = err_ff;

endmodule

>>> rtl/signed_add_sub_mul_div_unit.sv
// Top level of the signed add/subtract/multiply/divide unit.
//
// Request channel (req_): operation code and two signed operands, taken when
// req_valid is high and req_stall is low. Response channel (rsp_): result,
// nonnegative remainder and error code, handed over when rsp_valid is high and
// rsp_stall is low. One response per request, in order.
// Sequence, W = DATA_WIDTH, from the accepting edge to the edge that loads the
// response register; req_stall is high for that whole span:
//   add, subtract      straight to the response register
//   multiply           magnitudes of a and b, W shift-add steps, sign step
//   divide             magnitudes of a and b, a shift-subtract step per
//                      dividend bit, for a negative dividend a remainder
//                      check and, if it is nonzero, the remainder and quotient
//                      fixes, then sign step; divide by zero: magnitudes, sign step
// A new request is taken in the cycle after the response is loaded. All of the
// arithmetic runs through one shared adder.
// The response register frees the request side: a waiting response does not
// block the next request, but a finished result holds in the sequencer while
// rsp_stall keeps the previous one in place.
// Synchronous reset empties the response register and returns to idle.
`include "signed_add_sub_mul_div_unit_defines.svh"
module signed_add_sub_mul_div_unit #(
   parameter int DATA_WIDTH = sasmd_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic        [1:0]            req_operation,
   input  logic signed [DATA_WIDTH-1:0] req_operand_a,
   input  logic signed [DATA_WIDTH-1:0] req_operand_b,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_result_value,
   output logic        [DATA_WIDTH-2:0] rsp_remainder_value,
   output logic        [1:0]            rsp_error_code
);
   import sasmd_pkg::*;

   ctrl_type   ctrl;
   status_type status;
   op_type     req_op;

   assign req_op = op_type'(req_operation);

   sasmd_seq #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_operation(req_op),
      .status       (status),
      .ctrl         (ctrl),
      .req_stall    (req_stall)
   );

   sasmd_datapath #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .status             (status),
      .req_operation      (req_op),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_value   (rsp_result_value),
      .rsp_remainder_value(rsp_remainder_value),
      .rsp_error_code     (rsp_error_code)
   );

   `SASMD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall,
      req_stall, "request accepted but unit not busy next cycle")
   `SASMD_ASSERT(a_error_zero_payload, clock, reset,
      !rsp_valid || rsp_error_code == ERR_NONE
      || (rsp_result_value == '0 && rsp_remainder_value == '0),
      "error response with nonzero payload")
   `SASMD_ASSERT(a_response_from_busy, clock, reset, !$rose(rsp_valid) || $past(req_stall),
      "response appeared without a transaction in flight")

endmodule

>>> verif/signed_add_sub_mul_div_unit_tb.sv
// Self-checking testbench for the signed add/subtract/multiply/divide unit.
`timescale 1ns / 100ps

module signed_add_sub_mul_div_unit_tb;
   import sasmd_pkg::*;

   localparam int W           = 32;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 2 * W + 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;

   localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] ZERO    = '0;
   localparam logic [W-1:0] ONE     = {{(W-1){1'b0}}, 1'b1};
   localparam logic [W-1:0] NEG_ONE = '1;

   typedef struct {
      op_type         op;
      logic [W-1:0]   a;
      logic [W-1:0]   b;
      logic [W-1:0]   result;
      logic [W-2:0]   remainder;
      err_type        err;
   } arith_outcome_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_operation;
   logic signed [W-1:0] req_operand_a;
   logic signed [W-1:0] req_operand_b;
   logic                rsp_valid;
   logic                rsp_stall;
   logic signed [W-1:0] rsp_result_value;
   logic [W-2:0]        rsp_remainder_value;
   logic [1:0]          rsp_error_code;

   arith_outcome_type pending_outcomes[$];
   int             mismatch_count;
   int             cycle_count;
   int             op_tally[4];
   int             overflow_seen;
   int             div_zero_seen;
   int             euclid_fix_seen;
   bit             idling_enabled;
   int             hold_requests;
   int             hold_served;
   int             hold_left;

   signed_add_sub_mul_div_unit #(.DATA_WIDTH(W)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_operand_a       (req_operand_a),
      .req_operand_b       (req_operand_b),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_value    (rsp_result_value),
      .rsp_remainder_value (rsp_remainder_value),
      .rsp_error_code      (rsp_error_code)
   );

   always #4 clock = ~clock;

   // Expected result, remainder and error code for one transaction.
   function automatic arith_outcome_type predict_outcome(op_type op, logic [W-1:0] a,
                                                         logic [W-1:0] b);
      arith_outcome_type o;
      logic [W-1:0]   mag_a;
      logic [W-1:0]   mag_b;
      logic [W-1:0]   quo;
      logic [W-1:0]   rem;
      logic [2*W-1:0] prod;
      logic           neg;
      o.op        = op;
      o.a         = a;
      o.b         = b;
      o.result    = '0;
      o.remainder = '0;
      o.err       = ERR_NONE;
      mag_a = a[W-1] ? -a : a;
      mag_b = b[W-1] ? -b : b;
      neg   = a[W-1] ^ b[W-1];
      case (op)
         OP_ADD: o.result = a + b;
         OP_SUB: o.result = a - b;
         OP_MUL: begin
            prod = {{W{1'b0}}, mag_a} * {{W{1'b0}}, mag_b};
            // any bit at or above the sign position means the magnitude is too big
            if (prod[2*W-1:W-1] != '0) begin
               o.err = ERR_MUL_OVERFLOW;
            end else begin
               o.result = neg ? -prod[W-1:0] : prod[W-1:0];
            end
         end
         default: begin
            if (b == '0) begin
               o.err = ERR_DIV_ZERO;
            end else begin
               quo = mag_a / mag_b;
               rem = mag_a % mag_b;
               // round the quotient away so the remainder stays nonnegative
               if (a[W-1] && rem != '0) begin
                  quo = quo + 1'b1;
                  rem = mag_b - rem;
               end
               o.result    = neg ? -quo : quo;
               o.remainder = rem[W-2:0];
            end
         end
      endcase
      return o;
   endfunction

   function automatic logic [W-1:0] rand_operand();
      logic [W-1:0] v;
      case ($urandom_range(0, 5))
         0, 1: v = $urandom;
         2: v = $urandom_range(0, 200) - 100;
         3: begin
            case ($urandom_range(0, 5))
               0: v = MIN_VAL;
               1: v = MAX_VAL;
               2: v = ZERO;
               3: v = NEG_ONE;
               4: v = ONE;
               default: v = MIN_VAL + ONE;
            endcase
         end
         4: begin
            v = $urandom_range(0, 65535);
            if ($urandom_range(0, 1) == 1) v = -v;
         end
         default: begin
            v = ONE << $urandom_range(0, W - 1);
            if ($urandom_range(0, 1) == 1) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic bit roll_idle();
      return idling_enabled && ($urandom_range(0, 99) < 21);
   endfunction

   // Offer one transaction and hold it until the block takes it.
   task automatic send_item(op_type op, logic [W-1:0] a, logic [W-1:0] b);
      @(negedge clock);
      while (roll_idle()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (req_stall);
      pending_outcomes.push_back(predict_outcome(op, a, b));
      op_tally[op]++;
   endtask

   task automatic send_random();
      send_item(op_type'($urandom_range(0, 3)), rand_operand(), rand_operand());
   endtask

   task automatic release_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_all_results();
      release_request();
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic run_directed_edges();
      send_item(OP_ADD, MAX_VAL, ONE);
      send_item(OP_ADD, MIN_VAL, MIN_VAL);
      send_item(OP_ADD, NEG_ONE, ONE);
      send_item(OP_SUB, MIN_VAL, ONE);
      send_item(OP_SUB, ZERO, MIN_VAL);
      send_item(OP_SUB, MAX_VAL, NEG_ONE);
      send_item(OP_MUL, MAX_VAL, ONE);
      send_item(OP_MUL, MAX_VAL, NEG_ONE);
      send_item(OP_MUL, MIN_VAL, ONE);
      send_item(OP_MUL, MIN_VAL, ZERO);
      send_item(OP_MUL, 32'sd46341, 32'sd46341);
      send_item(OP_MUL, 32'sd46340, -32'sd46340);
      // product of exactly the most negative value still overflows
      send_item(OP_MUL, -32'sd65536, 32'sd32768);
      send_item(OP_MUL, NEG_ONE, NEG_ONE);
      send_item(OP_DIV, 32'sd5, ZERO);
      send_item(OP_DIV, MIN_VAL, ZERO);
      send_item(OP_DIV, 32'sd7, 32'sd2);
      send_item(OP_DIV, -32'sd7, 32'sd2);
      send_item(OP_DIV, -32'sd7, -32'sd2);
      send_item(OP_DIV, 32'sd7, -32'sd2);
      // quotient magnitude out of range wraps without an error
      send_item(OP_DIV, MIN_VAL, NEG_ONE);
      send_item(OP_DIV, MIN_VAL, MIN_VAL);
      send_item(OP_DIV, MAX_VAL, MIN_VAL);
      send_item(OP_DIV, MIN_VAL, MAX_VAL);
      send_item(OP_DIV, NEG_ONE, MIN_VAL);
   endtask

   task automatic run_random_mix(int count);
      repeat (count) send_random();
   endtask

   task automatic run_back_to_back(int count);
      idling_enabled = 1'b0;
      repeat (count) send_random();
      idling_enabled = 1'b1;
   endtask

   // Hold the response side so the block backs up into the request side.
   task automatic run_output_holdoff();
      idling_enabled = 1'b0;
      hold_requests++;
      repeat (20) send_random();
      idling_enabled = 1'b1;
   endtask

   task automatic run_drain_pause();
      repeat (30) send_random();
      wait_all_results();
      repeat (30) send_random();
   endtask

   // Response side: random stalls, or a counted hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= roll_idle();
      end
   end

   task automatic report_mismatch(string field, arith_outcome_type o, logic [W-1:0] expv,
                                  logic [W-1:0] actv);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch %s: op %s a %0d b %0d expected %0d (0x%h) got %0d (0x%h)",
                  field, o.op.name(), $signed(o.a), $signed(o.b),
                  $signed(expv), expv, $signed(actv), actv);
   endtask

   always @(posedge clock) begin
      arith_outcome_type o;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected transaction: result 0x%h remainder 0x%h error %0d",
                        rsp_result_value, rsp_remainder_value, rsp_error_code);
         end else begin
            o = pending_outcomes.pop_front();
            if (rsp_result_value !== o.result)
               report_mismatch("result", o, o.result, rsp_result_value);
            if (rsp_remainder_value !== o.remainder)
               report_mismatch("remainder", o, {1'b0, o.remainder}, {1'b0, rsp_remainder_value});
            if (rsp_error_code !== o.err)
               report_mismatch("error code", o, W'(o.err), W'(rsp_error_code));
            if (o.err == ERR_MUL_OVERFLOW) overflow_seen++;
            if (o.err == ERR_DIV_ZERO) div_zero_seen++;
            if (o.op == OP_DIV && o.a[W-1] && o.err == ERR_NONE && o.remainder != '0)
               euclid_fix_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d transactions outstanding",
                  cycle_count, pending_outcomes.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = OP_ADD;
      req_operand_a  = '0;
      req_operand_b  = '0;
      rsp_stall      = 1'b0;
      mismatch_count = 0;
      cycle_count    = 0;
      overflow_seen  = 0;
      div_zero_seen  = 0;
      euclid_fix_seen = 0;
      idling_enabled = 1'b1;
      hold_requests  = 0;
      hold_served    = 0;
      hold_left      = 0;
      foreach (op_tally[i]) op_tally[i] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed_edges();
      run_random_mix(300);
      run_back_to_back(150);
      run_output_holdoff();
      run_drain_pause();
      run_random_mix(260);

      wait_all_results();
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d transactions: %0d add, %0d subtract, %0d multiply, %0d divide",
               op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
               op_tally[0], op_tally[1], op_tally[2], op_tally[3]);
      $display("saw %0d multiply overflows, %0d divides by zero, %0d rounded quotients",
               overflow_seen, div_zero_seen, euclid_fix_seen);
      $display("%0d mismatches", mismatch_count);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
